@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during rst
`define SDN_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication, sampled on clk, off during rst
`define SDN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SDN_ASSERT_IMPLY(lbl, ante, cons)
`define SDN_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/sdn_pkg.sv @@
// ----------------------------------------------------------------------------
// sdn_pkg
// Shared types, constants and helpers of the steepest descent neighbor block.
// ----------------------------------------------------------------------------
package sdn_pkg;

  localparam int VALUE_BITS   = 32;
  localparam int CFG_W        = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int OUT_IX_W     = 21;
  localparam int DEF_MAX_ROWS = 1024;
  localparam int DEF_MAX_COLS = 1024;
  localparam int CMD_DEPTH    = 4;
  localparam int RES_DEPTH    = 8;
  localparam int RES_CNT_W    = $clog2(RES_DEPTH + 1);
  localparam int NBR          = 8;

  localparam logic [CFG_W-1:0] RESET_DIM = CFG_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_ROWS = 2'd0,
    REG_NUM_COLS = 2'd1
  } cfg_reg_t;

  // neighbor scan order
  localparam int NB_N  = 0;
  localparam int NB_NE = 1;
  localparam int NB_E  = 2;
  localparam int NB_SE = 3;
  localparam int NB_S  = 4;
  localparam int NB_SW = 5;
  localparam int NB_W  = 6;
  localparam int NB_NW = 7;

  // diagonal neighbors sit at odd scan positions
  localparam logic [NBR-1:0] NBR_DIAG = 8'b1010_1010;

  typedef struct packed {
    logic [VALUE_BITS-1:0] elev;
    logic                  missing;
    logic [VALUE_BITS-1:0] gdist;
    logic                  inf;
  } cell_t;

  localparam cell_t EMPTY_CELL = '{elev: '0, missing: 1'b1, gdist: '0, inf: 1'b1};

  typedef struct packed {
    logic emit;
    logic last;
  } step_t;

  typedef struct packed {
    logic [OUT_IX_W-1:0] receiver_index;
    logic                last;
  } result_t;

  function automatic logic [CFG_W-1:0] clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
    if (v == '0) return CFG_W'(1);
    else if (32'(v) > hi) return CFG_W'(hi);
    else return v;
  endfunction

  function automatic int cmd_width(int max_rows, int max_cols);
    return $bits(cell_t) + $bits(step_t) + 2 * $clog2(max_rows) + $clog2(max_cols + 1)
           + $clog2(max_rows * max_cols + 1);
  endfunction

endpackage

@@ sv/steepest_descent_neighbor.sv @@
// ----------------------------------------------------------------------------
// steepest_descent_neighbor
// D8 flow direction with flat routing over a column-major cell stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one cell per transfer, row index
//   running fastest; action = 1 marks a flush item that pads the last column.
//   Output channel (out_valid/out_stall) gives the 1-based receiver index per
//   cell, 0 when none, with last set on the final cell of the grid.
//   Config channel (cfg_valid/cfg_ready, always ready) writes num_rows (0) and
//   num_cols (1); a write restarts the grid. Write only while the block is idle.
//   The result for cell i transfers after item i + num_rows + 1, passing the
//   command queue, six stages through the two line buffer RAMs, the 3x3
//   window, squaring and selection, and the output queue. Throughput is one
//   item per cycle while out_stall is low, set by the single write/read port
//   of each line buffer RAM and the one-item-per-stage selection pipe.
//   Reset sets both dimensions to 1024 and the stream to the first cell.
//   When out_stall is held, up to 8 results wait in the output queue; the
//   back end then holds, the 4-entry command queue fills and in_stall rises.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module steepest_descent_neighbor #(
  parameter int MAX_ROWS = sdn_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = sdn_pkg::DEF_MAX_COLS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  action,
  input  logic signed [sdn_pkg::VALUE_BITS-1:0] elevation,
  input  logic                                  elevation_missing,
  input  logic [sdn_pkg::VALUE_BITS-1:0]        flat_distance,
  input  logic                                  flat_distance_infinite,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [sdn_pkg::OUT_IX_W-1:0]          receiver_index,
  output logic                                  last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sdn_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sdn_pkg::CFG_W-1:0]             cfg_data
);

  import sdn_pkg::*;

  localparam int CMD_W     = cmd_width(MAX_ROWS, MAX_COLS);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  logic                 cmd_push, cmd_full, cmd_valid, cmd_pop;
  logic [CMD_W-1:0]     cmd_wdata, cmd_rdata;
  logic [CMD_CNT_W-1:0] cmd_count;
  logic [CFG_W-1:0]     num_rows, num_cols;
  logic                 res_push, res_full, res_pop;
  result_t              res_wdata, res_rdata;
  logic [RES_CNT_W-1:0] res_count;

  assign cfg_ready = 1'b1;

  sdn_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
    .clk                    (clk),
    .rst                    (rst),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .action                 (action),
    .elevation              (elevation),
    .elevation_missing      (elevation_missing),
    .flat_distance          (flat_distance),
    .flat_distance_infinite (flat_distance_infinite),
    .cfg_valid              (cfg_valid),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .cmd_full               (cmd_full),
    .cmd_push               (cmd_push),
    .cmd_data               (cmd_wdata),
    .num_rows               (num_rows),
    .num_cols               (num_cols)
  );

  sdn_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .wr_data  (cmd_wdata),
    .pop      (cmd_pop),
    .rd_valid (cmd_valid),
    .rd_data  (cmd_rdata),
    .full     (cmd_full),
    .count    (cmd_count)
  );

  sdn_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .num_rows  (num_rows),
    .num_cols  (num_cols),
    .res_count (res_count),
    .res_push  (res_push),
    .res_data  (res_wdata)
  );

  sdn_fifo #(.WIDTH($bits(result_t)), .DEPTH(RES_DEPTH)) u_res_q (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .wr_data  (res_wdata),
    .pop      (res_pop),
    .rd_valid (out_valid),
    .rd_data  (res_rdata),
    .full     (res_full),
    .count    (res_count)
  );

  assign res_pop        = out_valid && !out_stall;
  assign receiver_index = res_rdata.receiver_index;
  assign last           = res_rdata.last;

  `SDN_ASSERT_IMPLY(a_cmd_no_overflow, cmd_push, !cmd_full)
  `SDN_ASSERT_IMPLY(a_cmd_pop_nonempty, cmd_pop, cmd_count != '0)
  `SDN_ASSERT_IMPLY(a_res_no_overflow, res_push, !res_full)
  `SDN_ASSERT_NEXT(a_res_shows_next, res_push && (res_count == '0), out_valid)

endmodule

@@ sv/sdn_ram.sv @@
// ----------------------------------------------------------------------------
// sdn_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module sdn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/sdn_fifo.sv @@
// ----------------------------------------------------------------------------
// sdn_fifo
// Small register queue; head entry is visible while rd_valid is high.
// ----------------------------------------------------------------------------
module sdn_fifo #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 4,
  localparam int AW    = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic [CNT_W-1:0] count
);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    rd_ptr;
  logic [AW-1:0]    wr_ptr;

  assign rd_valid = (count != '0);
  assign full     = (count == CNT_W'(DEPTH));
  assign rd_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/sdn_front.sv @@
// ----------------------------------------------------------------------------
// sdn_front
// Input side: configuration, stream position, sample/flush classification.
// ----------------------------------------------------------------------------
module sdn_front #(
  parameter int MAX_ROWS = sdn_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = sdn_pkg::DEF_MAX_COLS,
  localparam int CMD_W   = sdn_pkg::cmd_width(MAX_ROWS, MAX_COLS)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                action,
  input  logic signed [sdn_pkg::VALUE_BITS-1:0] elevation,
  input  logic                                elevation_missing,
  input  logic [sdn_pkg::VALUE_BITS-1:0]      flat_distance,
  input  logic                                flat_distance_infinite,
  input  logic                                cfg_valid,
  input  logic [sdn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sdn_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                cmd_full,
  output logic                                cmd_push,
  output logic [CMD_W-1:0]                    cmd_data,
  output logic [sdn_pkg::CFG_W-1:0]           num_rows,
  output logic [sdn_pkg::CFG_W-1:0]           num_cols
);

  import sdn_pkg::*;

  localparam int AW   = $clog2(MAX_ROWS);
  localparam int CW   = $clog2(MAX_COLS + 1);
  localparam int IX_W = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int P_W  = $clog2(MAX_ROWS * MAX_COLS + MAX_ROWS + 2);

  logic [P_W-1:0]  pos;
  logic [AW-1:0]   ptr;
  logic [AW-1:0]   row;
  logic [CW-1:0]   col;
  logic [IX_W-1:0] cix;

  logic [P_W-1:0]  total;
  logic            sample;
  cell_t           cur_cell;
  step_t           step;
  logic [AW-1:0]   ptr_next;

  assign in_stall = cmd_full;
  assign cmd_push = in_valid && !cmd_full;

  assign total     = P_W'(32'(num_rows) * 32'(num_cols));
  assign sample    = !action && (pos < total);
  assign step.emit = 32'(pos) > 32'(num_rows);
  assign step.last = step.emit && (32'(cix) + 1 == 32'(total));
  assign ptr_next  = (32'(ptr) + 1 >= 32'(num_rows)) ? '0 : ptr + AW'(1);

  always_comb begin
    if (sample) begin
      cur_cell.elev    = elevation;
      cur_cell.missing = elevation_missing;
      cur_cell.gdist   = flat_distance;
      cur_cell.inf     = flat_distance_infinite;
    end else begin
      cur_cell = EMPTY_CELL;
    end
  end

  assign cmd_data = {cur_cell, step, ptr, row, col, cix};

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= clamp_dim(RESET_DIM, MAX_ROWS);
      num_cols <= clamp_dim(RESET_DIM, MAX_COLS);
      pos      <= '0;
      ptr      <= '0;
      row      <= '0;
      col      <= '0;
      cix      <= '0;
    end else if (cfg_valid) begin
      // any known register write restarts the grid
      priority if (cfg_index == REG_NUM_ROWS) begin
        num_rows <= clamp_dim(cfg_data, MAX_ROWS);
        pos <= '0; ptr <= '0; row <= '0; col <= '0; cix <= '0;
      end else if (cfg_index == REG_NUM_COLS) begin
        num_cols <= clamp_dim(cfg_data, MAX_COLS);
        pos <= '0; ptr <= '0; row <= '0; col <= '0; cix <= '0;
      end else begin
        // drop writes to unknown indexes
      end
    end else if (cmd_push) begin
      if (step.last) begin
        pos <= '0; ptr <= '0; row <= '0; col <= '0; cix <= '0;
      end else begin
        pos <= pos + P_W'(1);
        ptr <= ptr_next;
        if (step.emit) begin
          cix <= cix + IX_W'(1);
          if (32'(row) + 1 >= 32'(num_rows)) begin
            row <= '0;
            col <= col + CW'(1);
          end else begin
            row <= row + AW'(1);
          end
        end
      end
    end
  end

endmodule

@@ sv/sdn_back.sv @@
// ----------------------------------------------------------------------------
// sdn_back
// Execution side: line buffers, 3x3 window and the receiver selection pipe.
// ----------------------------------------------------------------------------
module sdn_back #(
  parameter int MAX_ROWS = sdn_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = sdn_pkg::DEF_MAX_COLS,
  localparam int CMD_W   = sdn_pkg::cmd_width(MAX_ROWS, MAX_COLS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  logic [CMD_W-1:0]              cmd_data,
  output logic                          cmd_pop,
  input  logic [sdn_pkg::CFG_W-1:0]     num_rows,
  input  logic [sdn_pkg::CFG_W-1:0]     num_cols,
  input  logic [sdn_pkg::RES_CNT_W-1:0] res_count,
  output logic                          res_push,
  output sdn_pkg::result_t              res_data
);

  import sdn_pkg::*;

  localparam int AW   = $clog2(MAX_ROWS);
  localparam int CW   = $clog2(MAX_COLS + 1);
  localparam int IX_W = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int VB   = VALUE_BITS;

  // command fields
  cell_t           cell0;
  step_t           step0;
  logic [AW-1:0]   ptr0;
  logic [AW-1:0]   row0;
  logic [CW-1:0]   col0;
  logic [IX_W-1:0] ix0;

  assign {cell0, step0, ptr0, row0, col0, ix0} = cmd_data;

  logic v1, v2, v3, v4, v5, v6;
  logic [5:0] vld;

  assign vld     = {v1, v2, v3, v4, v5, v6};
  // hold off until the result queue has room for everything in flight
  assign cmd_pop = cmd_valid && (32'(res_count) + $countones(vld) < RES_DEPTH);

  // stage 1: first line buffer
  cell_t           line_a, line_b;
  cell_t           cell1, cell2, mid2;
  step_t           step1, step2, step3;
  logic [AW-1:0]   ptr1, row1, row2, row3;
  logic [CW-1:0]   col1, col2, col3;
  logic [IX_W-1:0] ix1, ix2, ix3;

  sdn_ram #(.WIDTH($bits(cell_t)), .DEPTH(MAX_ROWS)) u_line_a (
    .clk     (clk),
    .wr_en   (cmd_pop),
    .wr_addr (ptr0),
    .wr_data (cell0),
    .rd_en   (cmd_pop),
    .rd_addr (ptr0),
    .rd_data (line_a)
  );

  sdn_ram #(.WIDTH($bits(cell_t)), .DEPTH(MAX_ROWS)) u_line_b (
    .clk     (clk),
    .wr_en   (v1),
    .wr_addr (ptr1),
    .wr_data (line_a),
    .rd_en   (v1),
    .rd_addr (ptr1),
    .rd_data (line_b)
  );

  // window: win[j][k] holds the cell j rows-of-columns and k items back
  cell_t win [3][3];

  always_ff @(posedge clk) begin
    cell1 <= cell0; step1 <= step0; ptr1 <= ptr0; row1 <= row0; col1 <= col0; ix1 <= ix0;
    cell2 <= cell1; mid2 <= line_a; step2 <= step1; row2 <= row1; col2 <= col1; ix2 <= ix1;
    step3 <= step2; row3 <= row2; col3 <= col2; ix3 <= ix2;
    if (v2) begin
      for (int j = 0; j < 3; j++) begin
        win[j][2] <= win[j][1];
        win[j][1] <= win[j][0];
      end
      win[0][0] <= cell2;
      win[1][0] <= mid2;
      win[2][0] <= line_b;
    end
  end

  // stage 3: neighbor classification
  cell_t                 ctr;
  cell_t                 nb [NBR];
  logic [NBR-1:0]        inb;
  logic                  up, down, left, right, in_flat;
  logic [IX_W-1:0]       base, nrx;
  logic [IX_W-1:0]       idx3 [NBR];
  logic signed [VB:0]    diff [NBR];
  logic [NBR-1:0]        pos3, cand3, sill3;

  always_comb begin
    ctr       = win[1][1];
    nb[NB_N]  = win[1][2];
    nb[NB_NE] = win[0][2];
    nb[NB_E]  = win[0][1];
    nb[NB_SE] = win[0][0];
    nb[NB_S]  = win[1][0];
    nb[NB_SW] = win[2][0];
    nb[NB_W]  = win[2][1];
    nb[NB_NW] = win[2][2];

    up    = (row3 != '0);
    down  = (32'(row3) + 1 < 32'(num_rows));
    left  = (col3 != '0);
    right = (32'(col3) + 1 < 32'(num_cols));

    inb[NB_N]  = up;
    inb[NB_NE] = up && right;
    inb[NB_E]  = right;
    inb[NB_SE] = down && right;
    inb[NB_S]  = down;
    inb[NB_SW] = down && left;
    inb[NB_W]  = left;
    inb[NB_NW] = up && left;

    base = ix3 + IX_W'(1);
    nrx  = IX_W'(num_rows);
    idx3[NB_N]  = base - IX_W'(1);
    idx3[NB_NE] = base + nrx - IX_W'(1);
    idx3[NB_E]  = base + nrx;
    idx3[NB_SE] = base + nrx + IX_W'(1);
    idx3[NB_S]  = base + IX_W'(1);
    idx3[NB_SW] = base - nrx + IX_W'(1);
    idx3[NB_W]  = base - nrx;
    idx3[NB_NW] = base - nrx - IX_W'(1);

    in_flat = !ctr.inf && (ctr.gdist != '0);

    for (int k = 0; k < NBR; k++) begin
      diff[k]  = $signed({ctr.elev[VB-1], ctr.elev}) - $signed({nb[k].elev[VB-1], nb[k].elev});
      pos3[k]  = inb[k] && !nb[k].missing && !diff[k][VB] && (diff[k] != '0);
      cand3[k] = inb[k] && !nb[k].missing && (diff[k] == '0) && in_flat && !nb[k].inf;
      sill3[k] = cand3[k] && (nb[k].gdist == '0);
    end
  end

  step_t                 step4, step5, step6;
  logic                  cmiss4, cmiss5;
  logic [NBR-1:0]        pos4, cand4, sill4, pos5, sill5, flat5;
  logic [VB-1:0]         drop4 [NBR];
  logic [VB-1:0]         gn4 [NBR];
  logic [VB-1:0]         gc4;
  logic [IX_W-1:0]       idx4 [NBR];
  logic [IX_W-1:0]       idx5 [NBR];
  logic [2*VB-1:0]       sq5 [NBR];
  result_t               res6;

  // stage 4: squares and flat routing
  logic [NBR-1:0]        flat4;
  logic [2*VB-1:0]       sq4 [NBR];

  always_comb begin
    logic ok;
    for (int k = 0; k < NBR; k++) begin
      sq4[k] = (2*VB)'(drop4[k]) * (2*VB)'(drop4[k]);
      ok = (gn4[k] < gc4);
      for (int j = 0; j < k; j++) begin
        if (cand4[j] && !(gn4[k] < gn4[j])) begin
          ok = 1'b0;
        end
      end
      flat4[k] = cand4[k] && (sill4[k] || ok);
    end
  end

  // stage 5: steepest pick, last writer in scan order wins, a sill stops it
  logic [NBR-1:0]        evt;
  logic [IX_W-1:0]       rcv;

  always_comb begin
    logic          nm;
    logic          blocked;
    logic [2*VB:0] lhs, rhs;
    lhs = '0;
    rhs = '0;
    for (int k = 0; k < NBR; k++) begin
      nm = pos5[k];
      for (int j = 0; j < k; j++) begin
        lhs = NBR_DIAG[j] ? {sq5[k], 1'b0} : {1'b0, sq5[k]};
        rhs = NBR_DIAG[k] ? {sq5[j], 1'b0} : {1'b0, sq5[j]};
        if (pos5[j] && !(lhs > rhs)) begin
          nm = 1'b0;
        end
      end
      evt[k] = nm || flat5[k];
    end
    rcv     = '0;
    blocked = 1'b0;
    for (int k = 0; k < NBR; k++) begin
      if (!blocked && evt[k]) begin
        rcv = idx5[k];
      end
      if (sill5[k]) begin
        blocked = 1'b1;
      end
    end
    if (cmiss5) begin
      rcv = '0;
    end
  end

  always_ff @(posedge clk) begin
    step4  <= step3;
    cmiss4 <= ctr.missing;
    pos4   <= pos3;
    cand4  <= cand3;
    sill4  <= sill3;
    gc4    <= ctr.gdist;
    for (int k = 0; k < NBR; k++) begin
      drop4[k] <= diff[k][VB-1:0];
      gn4[k]   <= nb[k].gdist;
      idx4[k]  <= idx3[k];
      idx5[k]  <= idx4[k];
      sq5[k]   <= sq4[k];
    end
    step5  <= step4;
    cmiss5 <= cmiss4;
    pos5   <= pos4;
    sill5  <= sill4;
    flat5  <= flat4;
    step6  <= step5;
    res6.receiver_index <= OUT_IX_W'(rcv);
    res6.last           <= step5.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else begin
      v1 <= cmd_pop; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
    end
  end

  assign res_push = v6 && step6.emit;
  assign res_data = res6;

endmodule

@@ verif/steepest_descent_neighbor_tb.sv @@
// ----------------------------------------------------------------------------
// steepest_descent_neighbor_tb
// Streams small grids through the flow direction block and checks each
// receiver index and last flag against a scoreboard predictor, with random
// stalls on both channels and dimension changes between grids.
// ----------------------------------------------------------------------------
module steepest_descent_neighbor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sdn_pkg::*;

  localparam int MAX_DIM = 1024;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT = 4000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;
  localparam bit ACT_CELL = 1'b0;
  localparam bit ACT_FLUSH = 1'b1;
  localparam int ROW_STEP[8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
  localparam int COL_STEP[8] = '{0, 1, 1, 1, 0, -1, -1, -1};

  typedef struct {
    logic [OUT_IX_W-1:0] rcv;
    logic                fin;
  } route_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic signed [VALUE_BITS-1:0] elevation = '0;
  logic elevation_missing = 1'b0;
  logic [VALUE_BITS-1:0] flat_distance = '0;
  logic flat_distance_infinite = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [OUT_IX_W-1:0] receiver_index;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  steepest_descent_neighbor dut (.*);

  // predictor state
  int rows_m = MAX_DIM, cols_m = MAX_DIM;
  int pos_m, crow_m, ccol_m;
  longint z_at[int];
  bit nodata_at[int];
  longint unsigned g_at[int];
  bit outside_at[int];
  route_t routes_due[$];

  int errors = 0;
  int tx_idle_pct = 0, rx_idle_pct = 0;
  int quiet_cycles = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void restart_stream();
    pos_m = 0;
    crow_m = 0;
    ccol_m = 0;
    z_at.delete();
    nodata_at.delete();
    g_at.delete();
    outside_at.delete();
  endfunction

  function automatic int clamp_size(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  // d1 over s1 strictly steeper than d2 over s2 (s*s is 1 or 2)
  function automatic bit is_steeper(longint unsigned d1, bit diag1,
                                    longint unsigned d2, bit diag2);
    logic [127:0] a, b;
    a = 128'(d1) * 128'(d1);
    b = 128'(d2) * 128'(d2);
    if (diag2) a = a << 1;
    if (diag1) b = b << 1;
    return a > b;
  endfunction

  function automatic void route_cell(bit act, logic signed [31:0] z, bit zm,
                                     logic [31:0] g, bit gi);
    int total, p, ix, r, c, nix;
    longint zc, diff;
    longint unsigned gc, best_d;
    bit in_flat, have_best, best_diag, diag;
    route_t res;
    total = rows_m * cols_m;
    p = pos_m;
    if (act == ACT_CELL && p < total) begin
      z_at[p] = longint'(z);
      nodata_at[p] = zm;
      g_at[p] = longint'(g);
      outside_at[p] = gi;
    end else begin
      z_at[p] = 0;
      nodata_at[p] = 1'b1;
      g_at[p] = 0;
      outside_at[p] = 1'b1;
    end
    if (p < rows_m + 1) begin
      pos_m = p + 1;
      return;
    end
    ix = p - rows_m - 1;
    res.rcv = '0;
    if (!nodata_at[ix]) begin
      zc = z_at[ix];
      gc = g_at[ix];
      in_flat = !outside_at[ix] && gc != 0;
      have_best = 1'b0;
      best_diag = 1'b0;
      best_d = 0;
      for (int k = 0; k < 8; k++) begin
        r = crow_m + ROW_STEP[k];
        c = ccol_m + COL_STEP[k];
        if (r < 0 || r >= rows_m || c < 0 || c >= cols_m) continue;
        nix = c * rows_m + r;
        if (nodata_at[nix]) continue;
        diff = zc - z_at[nix];
        diag = k[0];
        if (diff > 0 && (!have_best || is_steeper(diff, diag, best_d, best_diag))) begin
          res.rcv = OUT_IX_W'(nix + 1);
          have_best = 1'b1;
          best_d = diff;
          best_diag = diag;
        end else if (diff == 0 && in_flat && !outside_at[nix]) begin
          if (g_at[nix] == 0) begin
            res.rcv = OUT_IX_W'(nix + 1);
            break;
          end
          if (g_at[nix] < gc) begin
            res.rcv = OUT_IX_W'(nix + 1);
            gc = g_at[nix];
          end
        end
      end
    end
    res.fin = (ix + 1 == total);
    routes_due.push_back(res);
    if (res.fin) restart_stream();
    else begin
      pos_m = p + 1;
      crow_m++;
      if (crow_m >= rows_m) begin
        crow_m = 0;
        ccol_m++;
      end
    end
  endfunction

  task automatic send_item(bit act, logic [31:0] z, bit zm, logic [31:0] g, bit gi);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    elevation <= z;
    elevation_missing <= zm;
    flat_distance <= g;
    flat_distance_infinite <= gi;
    do @(posedge clk); while (in_stall);
    route_cell(act, z, zm, g, gi);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (routes_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_NUM_ROWS) begin
      rows_m = clamp_size(CFG_W'(val));
      restart_stream();
    end else if (idx == REG_NUM_COLS) begin
      cols_m = clamp_size(CFG_W'(val));
      restart_stream();
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_cell(bit rough);
    logic [31:0] z, g;
    int pick;
    pick = $urandom_range(9);
    z = (pick < 7) ? 32'($urandom_range(3)) : $urandom;
    if (pick == 9) z = {$urandom_range(1) ? 16'h8000 : 16'h7fff, 16'($urandom)};
    pick = $urandom_range(9);
    g = (pick < 3) ? 32'd0 : (pick < 8) ? 32'($urandom_range(4)) : $urandom;
    send_item((rough && $urandom_range(19) == 0) ? ACT_FLUSH : ACT_CELL, z,
              $urandom_range(9) == 0, g, $urandom_range(4) == 0);
  endtask

  // cells of one grid, then the trailer that drains the last column
  task automatic send_grid(int nr, int nc, bit rough);
    for (int i = 0; i < nr * nc; i++) send_cell(rough);
    for (int i = 0; i <= nr; i++) begin
      if (rough && $urandom_range(3) == 0) send_cell(1'b0);
      else send_item(ACT_FLUSH, $urandom, $urandom_range(1), $urandom, $urandom_range(1));
    end
  endtask

  task automatic test_directed();
    write_reg(REG_NUM_ROWS, 3);
    write_reg(REG_NUM_COLS, 3);
    // diagonal drop 3 beats straight drop 2; center (1,1)
    send_item(ACT_CELL, 32'd5, 0, 32'd0, 1);
    send_item(ACT_CELL, 32'd7, 0, 32'd0, 1);
    send_item(ACT_CELL, 32'd4, 0, 32'd0, 1);
    send_item(ACT_CELL, 32'd6, 0, 32'd0, 1);
    send_item(ACT_CELL, 32'd7, 0, 32'd0, 1);
    send_item(ACT_CELL, 32'd6, 1, 32'd0, 1);
    send_item(ACT_CELL, 32'd7, 0, 32'd0, 1);
    send_item(ACT_CELL, 32'd5, 0, 32'd0, 1);
    send_item(ACT_CELL, 32'd9, 0, 32'd0, 1);
    for (int i = 0; i < 4; i++) send_item(ACT_FLUSH, '0, 0, '0, 0);
    // flat: sill, smaller distance, infinite neighbor, missing center
    send_item(ACT_CELL, 32'd2, 0, 32'd5, 0);
    send_item(ACT_CELL, 32'd2, 0, 32'd3, 0);
    send_item(ACT_CELL, 32'd2, 0, 32'd9, 1);
    send_item(ACT_CELL, 32'd2, 0, 32'd4, 0);
    send_item(ACT_CELL, 32'd2, 0, 32'd6, 0);
    send_item(ACT_CELL, 32'd2, 0, 32'd0, 0);
    send_item(ACT_CELL, 32'd2, 1, 32'd2, 0);
    send_item(ACT_CELL, 32'd2, 0, 32'd1, 0);
    send_item(ACT_FLUSH, 32'd2, 0, 32'd0, 0);
    for (int i = 0; i < 4; i++) send_item(ACT_CELL, 32'd1, 0, '0, 0);
    // elevation and distance extremes
    write_reg(REG_NUM_ROWS, 2);
    write_reg(REG_NUM_COLS, 2);
    write_reg(REG_SPARE, 5);
    send_item(ACT_CELL, 32'h7fffffff, 0, 32'hffffffff, 0);
    send_item(ACT_CELL, 32'h80000000, 0, 32'hffffffff, 0);
    send_item(ACT_CELL, 32'h80000000, 0, 32'h00000000, 0);
    send_item(ACT_CELL, 32'h7fffffff, 0, 32'hfffffffe, 0);
    for (int i = 0; i < 3; i++) send_item(ACT_FLUSH, '1, 1, '1, 1);
  endtask

  task automatic test_dim_limits();
    write_reg(REG_NUM_ROWS, 0);
    write_reg(REG_NUM_COLS, 0);
    send_grid(1, 1, 1'b0);
    // oversized column count clamps; run part of a grid, the next write restarts it
    write_reg(REG_NUM_ROWS, 1);
    write_reg(REG_NUM_COLS, 11'h7ff);
    for (int i = 0; i < 40; i++) send_cell(1'b1);
  endtask

  task automatic test_random(int tx_pct, int rx_pct, int n_items);
    int sent, nr, nc;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      nr = $urandom_range(1, 7);
      nc = $urandom_range(1, 7);
      write_reg(REG_NUM_ROWS, nr);
      write_reg(REG_NUM_COLS, nc);
      repeat ($urandom_range(1, 2)) begin
        send_grid(nr, nc, $urandom_range(3) == 0);
        sent += nr * nc + nr + 1;
      end
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    route_t want;
    if (!rst && out_valid && !out_stall) begin
      if (routes_due.size() == 0) begin
        $error("unexpected transfer: receiver_index %0d last %0b", receiver_index, last);
        errors++;
      end else begin
        want = routes_due.pop_front();
        if (receiver_index !== want.rcv) begin
          $error("receiver_index: expected %0d, got %0d", want.rcv, receiver_index);
          errors++;
        end
        if (last !== want.fin) begin
          $error("last: expected %0b, got %0b", want.fin, last);
          errors++;
        end
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("steepest_descent_neighbor_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    restart_stream();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_dim_limits();
    test_random(12, 86, 340);
    test_random(86, 12, 340);
    test_random(0, 0, 340);
    wait_drained();
    if (errors == 0) begin
      $display("steepest_descent_neighbor_tb: clean");
    end else begin
      $display("steepest_descent_neighbor_tb: errors");
    end
    $finish;
  end
endmodule
